FILE: hw/rtl/mac_pkg.sv
// Shared types, constants and helper functions of the motion alarm controller.
`timescale 1ns / 1ps

package mac_pkg;

  // Field and register widths
  localparam int SAMPLE_W     = 14;
  localparam int THRESH_W     = 14;
  localparam int TICK_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CMP_W        = (SAMPLE_W > THRESH_W) ? SAMPLE_W : THRESH_W;
  localparam int IN_FIELDS_W  = 1 + 3 * SAMPLE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Register reset values
  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(50);
  localparam logic [TICK_W-1:0]   ARM_RST    = TICK_W'(5000);
  localparam logic [TICK_W-1:0]   BLINK_RST  = TICK_W'(1000);
  localparam logic [TICK_W-1:0]   ENTRY_RST  = TICK_W'(3000);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH = 2'd0,
    CFG_ARM    = 2'd1,
    CFG_BLINK  = 2'd2,
    CFG_ENTRY  = 2'd3
  } cfg_idx_t;

  // Alarm modes, also the mode field of a result
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ARMED = 2'd1,
    MODE_PRE   = 2'd2,
    MODE_ALARM = 2'd3
  } mode_t;

  // One tick as it enters the block
  typedef struct packed {
    logic                       key_press;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } beat_t;

  // One result beat
  typedef struct packed {
    logic  green_led;
    logic  red_led;
    mode_t mode;
  } result_t;

  // Magnitude of a two's complement sample; the most negative value maps exactly
  function automatic logic [SAMPLE_W-1:0] sample_mag(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] u;
    u = s;
    return u[SAMPLE_W-1] ? (~u + SAMPLE_W'(1)) : u;
  endfunction

  // True when the magnitude strays from its baseline by more than the threshold
  function automatic logic motion_hit(input logic [SAMPLE_W-1:0] mag,
                                      input logic [SAMPLE_W-1:0] base,
                                      input logic [THRESH_W-1:0] thr);
    logic [SAMPLE_W-1:0] diff;
    diff = (mag >= base) ? (mag - base) : (base - mag);
    return CMP_W'(diff) > CMP_W'(thr);
  endfunction

endpackage

FILE: hw/rtl/mac_in_stage.sv
// Input register stage: captures one tick beat and holds it until the core steps.
`timescale 1ns / 1ps

module mac_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  mac_pkg::beat_t beat_in,
  input  logic          advance,
  output logic          beat_valid,
  output mac_pkg::beat_t beat_out
);

  logic           valid_r;
  logic           valid_nxt;
  mac_pkg::beat_t beat_r;
  logic           load;

  // Take a new beat when empty or when the held one moves on this cycle
  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= beat_in;
    end
  end

  assign beat_valid = valid_r;
  assign beat_out   = beat_r;

endmodule

FILE: hw/rtl/mac_core.sv
// Alarm core: configuration registers, tick counters, baselines and mode state machine.
`timescale 1ns / 1ps

module mac_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             step_en,
  input  mac_pkg::beat_t                   beat,
  output mac_pkg::result_t                 result
);

  localparam int SW = mac_pkg::SAMPLE_W;
  localparam int TW = mac_pkg::TICK_W;

  // Configuration registers
  logic [mac_pkg::THRESH_W-1:0] thresh_r;
  logic [TW-1:0]                arm_cfg_r;
  logic [TW-1:0]                blink_cfg_r;
  logic [TW-1:0]                entry_cfg_r;

  // Alarm state
  mac_pkg::mode_t mode_r, mode_nxt;
  logic           pending_r, pending_nxt;
  logic [TW-1:0]  arm_r, arm_nxt;
  logic [TW-1:0]  blink_r, blink_nxt;
  logic [TW-1:0]  entry_r, entry_nxt;
  logic [SW-1:0]  base_x_r, base_x_nxt;
  logic [SW-1:0]  base_y_r, base_y_nxt;
  logic [SW-1:0]  base_z_r, base_z_nxt;
  logic           green_r, green_nxt;
  logic           red_r, red_nxt;

  logic [SW-1:0]  mag_x, mag_y, mag_z;
  logic [TW-1:0]  arm_dec, blink_dec, entry_dec;
  logic           motion;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= mac_pkg::THRESH_RST;
      arm_cfg_r   <= mac_pkg::ARM_RST;
      blink_cfg_r <= mac_pkg::BLINK_RST;
      entry_cfg_r <= mac_pkg::ENTRY_RST;
    end else if (cfg_wr_en) begin
      unique case (mac_pkg::cfg_idx_t'(cfg_index))
        mac_pkg::CFG_THRESH: thresh_r    <= cfg_wdata[mac_pkg::THRESH_W-1:0];
        mac_pkg::CFG_ARM:    arm_cfg_r   <= cfg_wdata[TW-1:0];
        mac_pkg::CFG_BLINK:  blink_cfg_r <= cfg_wdata[TW-1:0];
        mac_pkg::CFG_ENTRY:  entry_cfg_r <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // Axis magnitudes and motion detect against the baselines
  assign mag_x  = mac_pkg::sample_mag(beat.accel_x);
  assign mag_y  = mac_pkg::sample_mag(beat.accel_y);
  assign mag_z  = mac_pkg::sample_mag(beat.accel_z);
  assign motion = mac_pkg::motion_hit(mag_x, base_x_r, thresh_r) ||
                  mac_pkg::motion_hit(mag_y, base_y_r, thresh_r) ||
                  mac_pkg::motion_hit(mag_z, base_z_r, thresh_r);

  // Count down toward zero, stopping there
  assign arm_dec   = (arm_r   != '0) ? (arm_r   - TW'(1)) : arm_r;
  assign blink_dec = (blink_r != '0) ? (blink_r - TW'(1)) : blink_r;
  assign entry_dec = (entry_r != '0) ? (entry_r - TW'(1)) : entry_r;

  // Step the mode state machine once per tick
  always_comb begin
    mode_nxt    = mode_r;
    pending_nxt = pending_r;
    arm_nxt     = arm_dec;
    blink_nxt   = blink_dec;
    entry_nxt   = entry_dec;
    base_x_nxt  = base_x_r;
    base_y_nxt  = base_y_r;
    base_z_nxt  = base_z_r;
    green_nxt   = green_r;
    red_nxt     = red_r;
    unique case (mode_r)
      mac_pkg::MODE_IDLE: begin
        if (beat.key_press) begin
          pending_nxt = 1'b1;
          arm_nxt     = arm_cfg_r;
          green_nxt   = 1'b1;
        end
        // Arm and calibrate once the delay has run out
        if (pending_nxt && (arm_nxt == '0)) begin
          blink_nxt  = blink_cfg_r;
          green_nxt  = 1'b0;
          base_x_nxt = mag_x;
          base_y_nxt = mag_y;
          base_z_nxt = mag_z;
          mode_nxt   = mac_pkg::MODE_ARMED;
        end
      end
      mac_pkg::MODE_ARMED: begin
        if (blink_dec == '0) begin
          blink_nxt = blink_cfg_r;
          green_nxt = !green_r;
        end
        // Key press wins over motion
        if (beat.key_press) begin
          green_nxt   = 1'b0;
          pending_nxt = 1'b0;
          mode_nxt    = mac_pkg::MODE_IDLE;
        end else if (motion) begin
          entry_nxt = entry_cfg_r;
          green_nxt = 1'b0;
          mode_nxt  = mac_pkg::MODE_PRE;
        end
      end
      mac_pkg::MODE_PRE: begin
        if (entry_dec == '0) begin
          red_nxt  = 1'b1;
          mode_nxt = mac_pkg::MODE_ALARM;
        end
        if (beat.key_press) begin
          red_nxt     = 1'b0;
          pending_nxt = 1'b0;
          mode_nxt    = mac_pkg::MODE_IDLE;
        end
      end
      mac_pkg::MODE_ALARM: begin
        if (beat.key_press) begin
          red_nxt     = 1'b0;
          pending_nxt = 1'b0;
          mode_nxt    = mac_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = mac_pkg::MODE_IDLE;
      end
    endcase
  end

  // Advance state only when a tick is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= mac_pkg::MODE_IDLE;
      pending_r <= 1'b0;
      arm_r     <= '0;
      blink_r   <= '0;
      entry_r   <= '0;
      base_x_r  <= '0;
      base_y_r  <= '0;
      base_z_r  <= '0;
      green_r   <= 1'b0;
      red_r     <= 1'b0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      pending_r <= pending_nxt;
      arm_r     <= arm_nxt;
      blink_r   <= blink_nxt;
      entry_r   <= entry_nxt;
      base_x_r  <= base_x_nxt;
      base_y_r  <= base_y_nxt;
      base_z_r  <= base_z_nxt;
      green_r   <= green_nxt;
      red_r     <= red_nxt;
    end
  end

  // Result of this tick is the state after the step
  assign result.green_led = green_nxt;
  assign result.red_led   = red_nxt;
  assign result.mode      = mode_nxt;

endmodule

FILE: hw/rtl/mac_out_stage.sv
// Result register stage: holds one result beat until the consumer takes it.
`timescale 1ns / 1ps

module mac_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  mac_pkg::result_t res_in,
  output logic             free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output mac_pkg::result_t res_out
);

  logic             valid_r;
  logic             valid_nxt;
  mac_pkg::result_t res_r;
  logic             load;

  // Slot opens when empty or when the held beat leaves this cycle
  assign free = !valid_r || out_tready;
  assign load = res_valid && free;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_tvalid = valid_r;
  assign res_out    = res_r;

endmodule

FILE: hw/rtl/motion_alarm_controller.sv
// A tick beat waits in the input register, the core steps on it, and the result
// is captured in the result register. One tick beat per cycle while out_tready is
// high; the two registers run as a two-stage pipe, the core stepping once per tick.
// Reset: synchronous active-low rst_n clears both stages, the mode (idle), the
// counters, baselines and LEDs, and loads the register defaults 50/5000/1000/3000.
`timescale 1ns / 1ps

module motion_alarm_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] key_press, [14:1] accel_x, [28:15] accel_y, [42:29] accel_z, rest zero
  input  logic [mac_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] green_led, [1] red_led, [3:2] mode, rest zero
  output logic [mac_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [mac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mac_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int SW = mac_pkg::SAMPLE_W;

  mac_pkg::beat_t   beat_in;
  mac_pkg::beat_t   beat_held;
  logic             beat_valid;
  logic             out_free;
  logic             step_en;
  mac_pkg::result_t result;
  mac_pkg::result_t result_held;

  // Unpack the input beat
  assign beat_in.key_press = in_tdata[0];
  assign beat_in.accel_x   = in_tdata[1 +: SW];
  assign beat_in.accel_y   = in_tdata[1 + SW +: SW];
  assign beat_in.accel_z   = in_tdata[1 + 2 * SW +: SW];

  // Step the core when a tick is held and the result slot can take it
  assign step_en = beat_valid && out_free;

  mac_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .beat_in    (beat_in),
    .advance    (out_free),
    .beat_valid (beat_valid),
    .beat_out   (beat_held)
  );

  mac_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .beat      (beat_held),
    .result    (result)
  );

  mac_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (beat_valid),
    .res_in     (result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_out    (result_held)
  );

  // Pack the result beat
  assign out_tdata = {{(mac_pkg::OUT_TDATA_W - mac_pkg::OUT_FIELDS_W){1'b0}},
                      result_held.mode, result_held.red_led, result_held.green_led};

endmodule

FILE: hw/rtl/mac_checker.sv
// Port-level checker for the motion alarm controller, bound to the top level.
`timescale 1ns / 1ps

module mac_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [mac_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mac_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [1:0] mode_f;
  logic       green_f;
  logic       red_f;

  assign green_f = out_tdata[0];
  assign red_f   = out_tdata[1];
  assign mode_f  = out_tdata[3:2];

  // No result beat right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled tick beat holds until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("stalled tick beat changed");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // Red is lit only in alarm
  a_red_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (mode_f != mac_pkg::MODE_ALARM) |-> !red_f)
    else $error("red LED on outside alarm");

  // Green is dark in pre-alarm and alarm
  a_green_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((mode_f == mac_pkg::MODE_PRE) || (mode_f == mac_pkg::MODE_ALARM))
    |-> !green_f)
    else $error("green LED on after motion");

endmodule

bind motion_alarm_controller mac_checker u_mac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
